/* src/down_counter_frequency_calibrator_macros.svh */
// Assertion macros used by the calibrator module.
`ifndef DOWN_COUNTER_FREQUENCY_CALIBRATOR_MACROS_SVH
`define DOWN_COUNTER_FREQUENCY_CALIBRATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Check an implication on every clock edge outside reset.
`define DCFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds.
`define DCFC_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DCFC_ASSERT(label, prop, msg)
`define DCFC_NEVER(label, cond, msg)
`endif

`endif

/* src/dcfc_pkg.sv */
package dcfc_pkg;

    localparam int unsigned CNT_W = 64;
    localparam int unsigned REG_W = 32;

    // Windows tried before giving up on a counter that never decreases
    localparam logic [2:0] MAX_TRIES = 3'd5;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_REFUSED  = 2'd1,
        STATUS_NO_DECR  = 2'd2
    } status_t;

    typedef enum logic {
        MODE_START = 1'b0,
        MODE_TICK  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        REG_ENABLED   = 2'd0,
        REG_TICK_FREQ = 2'd1,
        REG_WINDOW    = 2'd2,
        REG_PRESCALE  = 2'd3
    } reg_idx_t;

    localparam logic [REG_W-1:0] TICK_FREQ_RST = 32'd1000;
    localparam logic [REG_W-1:0] WINDOW_RST    = 32'd10;
    localparam logic [REG_W-1:0] PRESCALE_RST  = 32'd1;

endpackage

/* src/down_counter_frequency_calibrator.sv */
// Down-counter frequency calibrator. Send a start word (s_tuser = 0) carrying
// the counter reading to open a window, then one tick word (s_tuser = 1) per
// reference tick carrying the reading at that tick. Once window_ticks ticks
// have gone by and the counter has decreased, one result word gives
// (start - end) * prescale_divider * tick_frequency, modulo 2^64, divided by
// the ticks elapsed, with status 0. A window without a decrease reopens from
// the latest reading, up to five windows, then a result with status 2 ends
// the run. A start while disabled, or with window_ticks or prescale_divider
// at zero, answers at once with status 1; a start while busy drops the run.
// Ticks while idle are dropped. The tick that closes a successful window
// runs two shift-add multiplies and a restoring divide, all through one
// shared 64-bit adder; s_tready stays low meanwhile. The result sits in an
// output register, and s_tready also stays low while that result waits
// for m_tready; the next word can be taken at the edge where it leaves.
`include "down_counter_frequency_calibrator_macros.svh"

module down_counter_frequency_calibrator
    import dcfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // [63:0] count_value
    input  logic [0:0]           s_tuser,   // [0] mode
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,   // [63:0] frequency
    output logic [1:0]           m_tuser,   // [1:0] status
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_PRE,
        ST_MUL_FREQ,
        ST_DIV
    } state_t;

    // control state
    state_t             state_reg, state_next;
    logic               busy_reg, busy_next;
    logic [2:0]         try_reg, try_next;
    logic [REG_W-1:0]   ticks_reg, ticks_next;
    logic [5:0]         step_reg, step_next;
    logic               out_valid_reg, out_valid_next;

    // configuration registers
    logic               enabled_reg;
    logic [REG_W-1:0]   tick_freq_reg;
    logic [REG_W-1:0]   window_reg;
    logic [REG_W-1:0]   prescale_reg;

    // datapath
    logic [CNT_W-1:0]   start_reg, start_next;
    logic [CNT_W-1:0]   mcand_reg, mcand_next;
    logic [REG_W-1:0]   mplier_reg, mplier_next;
    logic [CNT_W-1:0]   acc_reg, acc_next;
    logic [REG_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   freq_reg, freq_next;
    status_t            status_reg, status_next;

    // shared adder
    logic [CNT_W-1:0]   alu_a, alu_b;
    logic               alu_cin;
    logic [CNT_W:0]     alu_sum;
    logic [REG_W:0]     rem_sh;
    logic               div_ge;

    logic               in_accept, out_free, cfg_write;
    logic [CNT_W-1:0]   count_in;
    logic [REG_W-1:0]   ticks_inc;
    logic [2:0]         try_inc;

    assign count_in  = s_tdata;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = freq_reg;
    assign m_tuser   = status_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_ENABLED:   prdata = {31'd0, enabled_reg};
            REG_TICK_FREQ: prdata = tick_freq_reg;
            REG_WINDOW:    prdata = window_reg;
            REG_PRESCALE:  prdata = prescale_reg;
            default:       prdata = '0;
        endcase
    end

    // Multiply: shift the accumulator left and add the multiplicand on a set
    // multiplier bit. Divide: shift the next dividend bit into the remainder
    // and subtract the tick count; the carry out says the subtract fits.
    assign rem_sh = {rem_reg, acc_reg[CNT_W-1]};

    always_comb
    begin
        if (state_reg == ST_DIV)
        begin
            alu_a   = {{(CNT_W-REG_W-1){1'b0}}, rem_sh};
            alu_b   = ~{{(CNT_W-REG_W){1'b0}}, ticks_reg};
            alu_cin = 1'b1;
        end
        else
        begin
            alu_a   = {acc_reg[CNT_W-2:0], 1'b0};
            alu_b   = mplier_reg[REG_W-1] ? mcand_reg : '0;
            alu_cin = 1'b0;
        end
    end

    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {{CNT_W{1'b0}}, alu_cin};
    assign div_ge  = alu_sum[CNT_W];

    assign ticks_inc = ticks_reg + 32'd1;
    assign try_inc   = try_reg + 3'd1;

    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        try_next       = try_reg;
        ticks_next     = ticks_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !m_tready;
        start_next     = start_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        freq_next      = freq_reg;
        status_next    = status_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (mode_t'(s_tuser[0]) == MODE_START)
                    begin
                        busy_next = 1'b0;
                        if (!enabled_reg || window_reg == '0 || prescale_reg == '0)
                        begin
                            out_valid_next = 1'b1;
                            freq_next      = '0;
                            status_next    = STATUS_REFUSED;
                        end
                        else
                        begin
                            busy_next  = 1'b1;
                            start_next = count_in;
                            ticks_next = '0;
                            try_next   = '0;
                        end
                    end
                    else if (busy_reg)
                    begin
                        ticks_next = ticks_inc;
                        if (ticks_inc >= window_reg)
                        begin
                            try_next = try_inc;
                            if (start_reg > count_in)
                            begin
                                // counter moved: compute the frequency
                                busy_next   = 1'b0;
                                mcand_next  = start_reg - count_in;
                                mplier_next = prescale_reg;
                                acc_next    = '0;
                                step_next   = 6'd31;
                                state_next  = ST_MUL_PRE;
                            end
                            else if (try_inc >= MAX_TRIES)
                            begin
                                busy_next      = 1'b0;
                                out_valid_next = 1'b1;
                                freq_next      = '0;
                                status_next    = STATUS_NO_DECR;
                            end
                            else
                            begin
                                // reopen the window from this reading
                                start_next = count_in;
                                ticks_next = '0;
                            end
                        end
                    end
                end
            end
            ST_MUL_PRE:
            begin
                acc_next    = alu_sum[CNT_W-1:0];
                mplier_next = {mplier_reg[REG_W-2:0], 1'b0};
                step_next   = step_reg - 6'd1;
                if (step_reg == '0)
                begin
                    mcand_next  = alu_sum[CNT_W-1:0];
                    mplier_next = tick_freq_reg;
                    acc_next    = '0;
                    step_next   = 6'd31;
                    state_next  = ST_MUL_FREQ;
                end
            end
            ST_MUL_FREQ:
            begin
                acc_next    = alu_sum[CNT_W-1:0];
                mplier_next = {mplier_reg[REG_W-2:0], 1'b0};
                step_next   = step_reg - 6'd1;
                if (step_reg == '0)
                begin
                    rem_next   = '0;
                    step_next  = 6'd63;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = div_ge ? alu_sum[REG_W-1:0] : rem_sh[REG_W-1:0];
                acc_next  = {acc_reg[CNT_W-2:0], div_ge};
                step_next = step_reg - 6'd1;
                if (step_reg == '0)
                begin
                    out_valid_next = 1'b1;
                    freq_next      = {acc_reg[CNT_W-2:0], div_ge};
                    status_next    = STATUS_OK;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= 1'b0;
            try_reg       <= '0;
            ticks_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            start_reg     <= '0;
            enabled_reg   <= 1'b0;
            tick_freq_reg <= TICK_FREQ_RST;
            window_reg    <= WINDOW_RST;
            prescale_reg  <= PRESCALE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            try_reg       <= try_next;
            ticks_reg     <= ticks_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            start_reg     <= start_next;
            if (cfg_write)
            begin
                unique case (reg_idx_t'(paddr[3:2]))
                    REG_ENABLED:   enabled_reg   <= pwdata[0];
                    REG_TICK_FREQ: tick_freq_reg <= pwdata;
                    REG_WINDOW:    window_reg    <= pwdata;
                    REG_PRESCALE:  prescale_reg  <= pwdata;
                    default:       enabled_reg   <= enabled_reg;
                endcase
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        freq_reg   <= freq_next;
        status_reg <= status_next;
    end

    // the divide always ends in a waiting result
    `DCFC_ASSERT(a_div_done_emits,
        (state_reg == ST_DIV && step_reg == 6'd0) |=> m_tvalid,
        "divide finished without a result")
    // an error result never carries a frequency
    `DCFC_ASSERT(a_err_zero_freq,
        (m_tvalid && m_tuser != STATUS_OK) |-> (m_tdata == '0),
        "error result with nonzero frequency")
    // no window stays open while the arithmetic runs
    `DCFC_NEVER(a_no_busy_in_calc,
        (state_reg != ST_IDLE) && busy_reg,
        "window open during calculation")
    // retries never run past the limit
    `DCFC_NEVER(a_try_bound,
        busy_reg && (try_reg >= MAX_TRIES),
        "retry count past limit while busy")

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import dcfc_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 1750;
    localparam int unsigned SETTLE_CYCLES = 200;     // margin after the last result, longer than a closing tick
    localparam int unsigned LONG_HOLD     = 600;     // receiver hold-off for the pressure phase
    localparam int unsigned CYCLE_LIMIT   = 1000000;

    typedef struct {
        mode_t       mode;
        logic [63:0] reading;
    } stream_word_t;

    typedef struct {
        logic [63:0] freq;
        status_t     status;
    } freq_result_t;

    logic        clk;
    logic        rst_n    = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;     // [63:0] count_value
    logic [0:0]  s_tuser  = '0;     // [0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;           // [63:0] frequency
    logic [1:0]  m_tuser;           // [1:0] status

    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    down_counter_frequency_calibrator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Register mirror and measurement state of the calibrator
    // ------------------------------------------------------------------
    logic        cfg_enabled   = 1'b0;
    logic [31:0] cfg_tick_freq = TICK_FREQ_RST;
    logic [31:0] cfg_window    = WINDOW_RST;
    logic [31:0] cfg_prescale  = PRESCALE_RST;

    logic        meas_busy  = 1'b0;
    logic [63:0] meas_start = '0;
    logic [31:0] meas_ticks = '0;
    logic [2:0]  meas_tries = '0;

    stream_word_t pending_words[$];
    freq_result_t expected_results[$];

    int unsigned words_queued   = 0;
    int unsigned words_accepted = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned hold_requests  = 0;
    int unsigned holds_served   = 0;

    // Work out what one accepted word does to the measurement and queue
    // the result word it causes, if any.
    task automatic predict_word(input mode_t mode, input logic [63:0] reading);
        freq_result_t res;
        logic [63:0]  delta;
        logic [63:0]  product;
        if (mode == MODE_START)
        begin
            // a start always drops whatever run was going on
            meas_busy = 1'b0;
            if (cfg_enabled == 1'b0 || cfg_window == '0 || cfg_prescale == '0)
            begin
                res.freq   = '0;
                res.status = STATUS_REFUSED;
                expected_results.push_back(res);
            end
            else
            begin
                meas_busy  = 1'b1;
                meas_start = reading;
                meas_ticks = '0;
                meas_tries = '0;
            end
        end
        else if (meas_busy)
        begin
            meas_ticks = meas_ticks + 32'd1;
            if (meas_ticks >= cfg_window)
            begin
                meas_tries = meas_tries + 3'd1;
                if (meas_start > reading)
                begin
                    // product wraps at 64 bits before the divide
                    delta      = meas_start - reading;
                    product    = delta * {32'd0, cfg_prescale} * {32'd0, cfg_tick_freq};
                    res.freq   = product / {32'd0, meas_ticks};
                    res.status = STATUS_OK;
                    expected_results.push_back(res);
                    meas_busy  = 1'b0;
                end
                else if (meas_tries >= MAX_TRIES)
                begin
                    res.freq   = '0;
                    res.status = STATUS_NO_DECR;
                    expected_results.push_back(res);
                    meas_busy  = 1'b0;
                end
                else
                begin
                    // reopen the window from this reading
                    meas_start = reading;
                    meas_ticks = '0;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    stream_word_t next_word;
    int unsigned  burst_left;
    int unsigned  gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                next_word = pending_words.pop_front();
                s_tvalid  <= 1'b1;
                s_tdata   <= next_word.reading;
                s_tuser   <= next_word.mode;
                if (burst_left <= 1)
                begin
                    // a quarter of the bursts run back to back with the next
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: own stall pattern, plus one long hold-off on request
    // ------------------------------------------------------------------
    int unsigned rx_style;
    int unsigned rx_style_left;
    int unsigned hold_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready      <= 1'b0;
            rx_style      <= 0;
            rx_style_left <= 0;
            hold_left     <= 0;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served <= hold_requests;
            hold_left    <= LONG_HOLD;
            m_tready     <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            if (rx_style_left == 0)
            begin
                rx_style      <= $urandom_range(0, 2);
                rx_style_left <= $urandom_range(20, 300);
            end
            else
            begin
                rx_style_left <= rx_style_left - 1;
            end
            // always ready, coin toss, or mostly stalled
            case (rx_style)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on accepted input words, check result words
    // ------------------------------------------------------------------
    freq_result_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_word(mode_t'(s_tuser[0]), s_tdata);
                words_accepted = words_accepted + 1;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result word with none expected: frequency %h status %0d",
                             $time, m_tdata, m_tuser);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.freq)
                    begin
                        $display("%0t: frequency expected %h actual %h",
                                 $time, want.freq, m_tdata);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tuser);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
        end
    end

    // Drop the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_word(input mode_t mode, input logic [63:0] reading);
        stream_word_t w;
        w.mode    = mode;
        w.reading = reading;
        pending_words.push_back(w);
        words_queued = words_queued + 1;
    endtask

    // Hold until every queued word is taken and every result has arrived,
    // then let the block finish any closing tick still in its datapath.
    task automatic wait_idle();
        while (words_accepted != words_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ENABLED:   cfg_enabled   = value[0];
            REG_TICK_FREQ: cfg_tick_freq = value;
            REG_WINDOW:    cfg_window    = value;
            REG_PRESCALE:  cfg_prescale  = value;
        endcase
    endtask

    // One well-formed run: a start, then full windows of ticks. Most runs
    // close on the first window; the rest miss a few windows first, and
    // five misses end in the no-decrease status.
    task automatic gen_measurement(input int unsigned win);
        logic [63:0] level;
        logic [63:0] delta;
        int unsigned misses;
        level  = rand64();
        misses = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 5);
        push_word(MODE_START, level);
        for (int unsigned t = 0; t <= misses; t++)
        begin
            repeat (win - 1) push_word(MODE_TICK, rand64());
            delta = rand64() >> $urandom_range(0, 63);
            if (t < misses || misses == 5)
            begin
                // hold or raise the reading: no decrease in this window
                level = (delta > ~level) ? level : level + delta;
            end
            else
            begin
                level = level - ((delta > level) ? level : delta);
            end
            push_word(MODE_TICK, level);
        end
    endtask

    initial
    begin
        int unsigned quota;
        int unsigned phase_end;
        int unsigned stop_at;
        int unsigned seq_win;
        int unsigned pick;
        logic [31:0] new_window;
        logic [31:0] new_freq;
        logic [31:0] new_prescale;
        logic        new_enabled;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Disabled after reset: a start is refused, a tick while idle is dropped.
        push_word(MODE_START, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(MODE_TICK, 64'd0);
        wait_idle();
        write_reg(REG_ENABLED, 32'd1);
        write_reg(REG_WINDOW, 32'd2);

        // widest possible delta, product wraps
        push_word(MODE_START, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(MODE_TICK, 64'd5);
        push_word(MODE_TICK, 64'd0);
        // start while busy drops the first run
        push_word(MODE_START, 64'd100);
        push_word(MODE_TICK, 64'd50);
        push_word(MODE_START, 64'd1000);
        push_word(MODE_TICK, 64'd999);
        push_word(MODE_TICK, 64'd990);
        // counter stuck at zero: five windows, then give up
        push_word(MODE_START, 64'd0);
        repeat (10) push_word(MODE_TICK, 64'd0);
        // one missed window, then success from the reopened sample
        push_word(MODE_START, 64'd7);
        push_word(MODE_TICK, 64'd3);
        push_word(MODE_TICK, 64'd7);
        push_word(MODE_TICK, 64'd9);
        push_word(MODE_TICK, 64'd1);
        // leave a window open across register changes
        push_word(MODE_START, 64'd500);
        push_word(MODE_TICK, 64'd400);
        wait_idle();
        write_reg(REG_WINDOW, 32'd1);
        write_reg(REG_TICK_FREQ, 32'hFFFF_FFFF);
        write_reg(REG_PRESCALE, 32'hFFFF_FFFF);
        // closes with two ticks elapsed against a window of one
        push_word(MODE_TICK, 64'd100);
        push_word(MODE_START, 64'h8000_0000_0000_0000);
        wait_idle();
        // prescaler zeroed under an open window: frequency 0, status ok
        write_reg(REG_PRESCALE, 32'd0);
        push_word(MODE_TICK, 64'd1);
        push_word(MODE_START, 64'd5);
        wait_idle();
        write_reg(REG_PRESCALE, 32'd1);
        write_reg(REG_WINDOW, 32'd0);
        write_reg(REG_TICK_FREQ, 32'd1);
        push_word(MODE_START, 64'd5);
        wait_idle();

        // Pressure: refused starts pile up behind a long receiver hold-off.
        write_reg(REG_ENABLED, 32'd0);
        hold_requests = hold_requests + 1;
        repeat (40) push_word(MODE_START, rand64());

        // Random phases, each under its own register setting.
        stop_at = words_queued + RANDOM_ITEMS;
        while (words_queued < stop_at)
        begin
            wait_idle();
            new_enabled = ($urandom_range(0, 9) != 0);
            case ($urandom_range(0, 9))
                0:       new_window = 32'd0;
                1:       new_window = 32'hFFFF_FFFF;
                default: new_window = $urandom_range(1, 5);
            endcase
            case ($urandom_range(0, 3))
                0:       new_freq = 32'd1;
                1:       new_freq = 32'hFFFF_FFFF;
                2:       new_freq = ($urandom == 0) ? 32'd1 : $urandom;
                default: new_freq = 32'd1000;
            endcase
            case ($urandom_range(0, 7))
                0:       new_prescale = 32'd0;
                1:       new_prescale = 32'hFFFF_FFFF;
                2:       new_prescale = $urandom;
                default: new_prescale = $urandom_range(1, 16);
            endcase
            write_reg(REG_ENABLED, {31'd0, new_enabled});
            write_reg(REG_TICK_FREQ, new_freq);
            write_reg(REG_WINDOW, new_window);
            write_reg(REG_PRESCALE, new_prescale);

            // phases that refuse every start or never close stay short
            if (!new_enabled || new_prescale == '0 || new_window == '0
                || new_window == 32'hFFFF_FFFF)
                quota = 40;
            else
                quota = 150;
            seq_win   = (new_window == '0) ? 1 : ((new_window > 32'd6) ? 4 : new_window);
            phase_end = words_queued + quota;

            // ticks that may land in a window left open by the last phase
            if ($urandom_range(0, 1) == 1)
                repeat ($urandom_range(1, 3)) push_word(MODE_TICK, rand64());

            while (words_queued < phase_end)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    push_word(mode_t'($urandom_range(0, 1)), rand64());
                end
                else if (pick == 1)
                begin
                    // broken run: cut short, the next start drops it
                    push_word(MODE_START, rand64());
                    repeat ($urandom_range(0, seq_win - 1)) push_word(MODE_TICK, rand64());
                end
                else
                begin
                    gen_measurement(seq_win);
                end
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
